FILE: src/tkd_pkg.sv
// Shared types, sizing constants and codes for the touch key charge time detector.
// Used by tkd_datapath, tkd_ctrl and the top level; depends on nothing.
`timescale 1ns / 1ps

package tkd_pkg;

    // Calibration store sizing
    localparam int CAL_SAMPLES   = 10;
    localparam int TRIM_EACH_END = 2;

    // Trim window; falls back to the whole store when the trim eats everything
    localparam int TRIM_OK  = (2 * TRIM_EACH_END < CAL_SAMPLES) ? 1 : 0;
    localparam int KEEP_LO  = (TRIM_OK != 0) ? TRIM_EACH_END : 0;
    localparam int KEEP     = (TRIM_OK != 0) ? (CAL_SAMPLES - 2 * TRIM_EACH_END) : CAL_SAMPLES;

    // Sum of the kept samples
    localparam int SUM_W = 16 + $clog2(KEEP + 1);

    // Divide by KEEP as a multiply by ceil(2^DIV_SHIFT / KEEP); exact for any SUM_W-bit sum
    localparam int     DIV_SHIFT = SUM_W + $clog2(KEEP);
    localparam longint RECIP     = ((longint'(1) << DIV_SHIFT) + KEEP - 1) / KEEP;
    localparam int     RECIP_W   = SUM_W + 1;
    localparam int     PROD_W    = SUM_W + RECIP_W;

    // Indexes and counters
    localparam int IDX_W  = $clog2(CAL_SAMPLES);
    localparam int STEP_W = $clog2(CAL_SAMPLES + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GATE_OFFSET    = 3'd0,
        REG_CEILING_FACTOR = 3'd1,
        REG_HOLDOFF_RELOAD = 3'd2,
        REG_NORMAL_GROUP   = 3'd3,
        REG_REPEAT_GROUP   = 3'd4
    } cfg_reg_t;

    // Field codes
    localparam logic OP_CAL       = 1'b0;
    localparam logic OP_SCAN      = 1'b1;
    localparam logic KIND_BASE    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Channel payloads
    typedef struct packed {
        logic        op;
        logic [15:0] sample;
        logic        repeat_mode;
    } in_t;

    typedef struct packed {
        logic        kind;
        logic        pressed;
        logic [15:0] baseline;
        logic [15:0] peak;
    } out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              cal_accept;
        logic              scan_accept;
        logic              sort_step;
        logic              sort_odd;
        logic              sum_clear;
        logic              sum_add;
        logic              div_step;
        logic              base_out;
        logic              scan_out;
        logic [STEP_W-1:0] step;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_cal;
        logic cal_last;
        logic group_last;
        logic out_free;
    } status_t;

endpackage

FILE: src/tkd_datapath.sv
// Datapath: calibration store with odd-even sort, trimmed sum, reciprocal divide,
// scan group tracking, press window check and output register. Depends on tkd_pkg.
`timescale 1ns / 1ps

module tkd_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tkd_pkg::in_t                   in_data,
    input  tkd_pkg::cmd_t                  cmd,
    output tkd_pkg::status_t               status,
    input  logic                           cfg_we,
    input  logic [tkd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tkd_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output tkd_pkg::out_t                  out_data
);

    // Configuration registers
    logic [15:0] gate_offset_reg;
    logic [3:0]  ceiling_factor_reg;
    logic [3:0]  holdoff_reload_reg;
    logic [3:0]  normal_group_reg;
    logic [3:0]  repeat_group_reg;

    // Control state
    logic [15:0]               baseline_reg, baseline_next;
    logic [tkd_pkg::IDX_W-1:0] cal_count_reg, cal_count_next;
    logic [3:0]                group_count_reg, group_count_next;
    logic [3:0]                group_target_reg, group_target_next;
    logic [15:0]               peak_reg, peak_next;
    logic [3:0]                holdoff_reg, holdoff_next;
    logic                      out_valid_reg, out_valid_next;

    // Payload state
    logic [15:0]               store_reg [tkd_pkg::CAL_SAMPLES];
    logic [15:0]               store_next [tkd_pkg::CAL_SAMPLES];
    logic [tkd_pkg::SUM_W-1:0] sum_reg, sum_next;
    tkd_pkg::out_t             out_data_reg, out_data_next;

    // Scan group terms
    logic       group_first;
    logic [3:0] target_pick;
    logic [3:0] target_now;
    logic [4:0] count_inc;

    // Divider terms
    logic [tkd_pkg::PROD_W-1:0] div_prod;

    // Window terms
    logic [16:0]               win_low;
    logic [19:0]               win_high;
    logic                      in_window;
    logic                      press_now;
    logic [3:0]                hold_loaded;
    logic [tkd_pkg::IDX_W-1:0] sum_idx;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_offset_reg    <= 16'd100;
            ceiling_factor_reg <= 4'd10;
            holdoff_reload_reg <= 4'd3;
            normal_group_reg   <= 4'd3;
            repeat_group_reg   <= 4'd6;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tkd_pkg::REG_GATE_OFFSET:    gate_offset_reg    <= cfg_data;
                tkd_pkg::REG_CEILING_FACTOR: ceiling_factor_reg <= cfg_data[3:0];
                tkd_pkg::REG_HOLDOFF_RELOAD: holdoff_reload_reg <= cfg_data[3:0];
                tkd_pkg::REG_NORMAL_GROUP:   normal_group_reg   <= cfg_data[3:0];
                tkd_pkg::REG_REPEAT_GROUP:   repeat_group_reg   <= cfg_data[3:0];
                default:                     ;
            endcase
        end
    end

    // Group target and end-of-group detect for the sample at the input
    always_comb
    begin
        group_first = (group_count_reg == 4'd0);
        target_pick = in_data.repeat_mode ? repeat_group_reg : normal_group_reg;
        if (target_pick == 4'd0)
        begin
            target_pick = 4'd1;
        end
        target_now = group_first ? target_pick : group_target_reg;
        count_inc  = {1'b0, group_count_reg} + 5'd1;
    end

    // Status to controller
    always_comb
    begin
        status.in_cal     = (in_data.op == tkd_pkg::OP_CAL);
        status.cal_last   = (cal_count_reg == tkd_pkg::IDX_W'(tkd_pkg::CAL_SAMPLES - 1));
        status.group_last = (count_inc >= {1'b0, target_now});
        status.out_free   = !out_valid_reg || !out_stall;
    end

    // Divide by KEEP as a multiply by its scaled reciprocal
    always_comb
    begin
        div_prod = tkd_pkg::PROD_W'(sum_reg) * tkd_pkg::PROD_W'(tkd_pkg::RECIP);
    end

    // Press window and hold-off
    always_comb
    begin
        win_low     = {1'b0, baseline_reg} + {1'b0, gate_offset_reg};
        win_high    = 20'(ceiling_factor_reg) * 20'(baseline_reg);
        in_window   = ({1'b0, peak_reg} > win_low) && (20'(peak_reg) < win_high);
        press_now   = in_window && (holdoff_reg == 4'd0);
        hold_loaded = in_window ? holdoff_reload_reg : holdoff_reg;
    end

    assign sum_idx = tkd_pkg::IDX_W'(tkd_pkg::KEEP_LO) + cmd.step[tkd_pkg::IDX_W-1:0];

    // Next state
    always_comb
    begin
        baseline_next     = baseline_reg;
        cal_count_next    = cal_count_reg;
        group_count_next  = group_count_reg;
        group_target_next = group_target_reg;
        peak_next         = peak_reg;
        holdoff_next      = holdoff_reg;
        store_next        = store_reg;
        sum_next          = sum_reg;
        out_data_next     = out_data_reg;
        out_valid_next    = out_valid_reg && out_stall;

        // Calibration sample shifts into the store
        if (cmd.cal_accept)
        begin
            store_next[0] = in_data.sample;
            for (int i = 1; i < tkd_pkg::CAL_SAMPLES; i++)
            begin
                store_next[i] = store_reg[i-1];
            end
            cal_count_next = status.cal_last ? '0 : cal_count_reg + 1'b1;
        end

        // Scan sample updates the running group
        if (cmd.scan_accept)
        begin
            if (group_first)
            begin
                group_target_next = target_pick;
                peak_next         = in_data.sample;
                if (in_data.repeat_mode)
                begin
                    holdoff_next = 4'd0;
                end
            end
            else if (in_data.sample > peak_reg)
            begin
                peak_next = in_data.sample;
            end
            group_count_next = status.group_last ? 4'd0 : count_inc[3:0];
        end

        // One odd-even transposition pass over neighbor pairs
        if (cmd.sort_step)
        begin
            for (int i = 0; i + 1 < tkd_pkg::CAL_SAMPLES; i++)
            begin
                if ((i % 2) == int'(cmd.sort_odd) && store_reg[i] > store_reg[i+1])
                begin
                    store_next[i]   = store_reg[i+1];
                    store_next[i+1] = store_reg[i];
                end
            end
        end

        if (cmd.sum_clear)
        begin
            sum_next = '0;
        end

        if (cmd.sum_add)
        begin
            sum_next = sum_reg + tkd_pkg::SUM_W'(store_reg[sum_idx]);
        end

        // Quotient replaces the sum
        if (cmd.div_step)
        begin
            sum_next = tkd_pkg::SUM_W'(div_prod >> tkd_pkg::DIV_SHIFT);
        end

        if (cmd.base_out)
        begin
            baseline_next          = sum_reg[15:0];
            out_data_next.kind     = tkd_pkg::KIND_BASE;
            out_data_next.pressed  = 1'b0;
            out_data_next.baseline = sum_reg[15:0];
            out_data_next.peak     = 16'd0;
            out_valid_next         = 1'b1;
        end

        if (cmd.scan_out)
        begin
            holdoff_next           = (hold_loaded != 4'd0) ? hold_loaded - 4'd1 : 4'd0;
            out_data_next.kind     = tkd_pkg::KIND_VERDICT;
            out_data_next.pressed  = press_now;
            out_data_next.baseline = baseline_reg;
            out_data_next.peak     = peak_reg;
            out_valid_next         = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg     <= '0;
            cal_count_reg    <= '0;
            group_count_reg  <= '0;
            group_target_reg <= '0;
            peak_reg         <= '0;
            holdoff_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            baseline_reg     <= baseline_next;
            cal_count_reg    <= cal_count_next;
            group_count_reg  <= group_count_next;
            group_target_reg <= group_target_next;
            peak_reg         <= peak_next;
            holdoff_reg      <= holdoff_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        store_reg    <= store_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: src/tkd_ctrl.sv
// Controller: sequences accept, sort passes, trimmed sum, divide and result load.
// Drives tkd_datapath through cmd_t and reads status_t. Depends on tkd_pkg.
`timescale 1ns / 1ps

module tkd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  tkd_pkg::status_t status,
    output tkd_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_SUM,
        ST_DIV,
        ST_BOUT,
        ST_EVAL
    } state_t;

    state_t                     state_reg, state_next;
    logic [tkd_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       accept;
    logic                       step_end;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    // Last step of the current phase
    always_comb
    begin
        unique case (state_reg)
            ST_SORT: step_end = (step_reg == tkd_pkg::STEP_W'(tkd_pkg::CAL_SAMPLES - 1));
            ST_SUM:  step_end = (step_reg == tkd_pkg::STEP_W'(tkd_pkg::KEEP - 1));
            default: step_end = 1'b0;
        endcase
    end

    // Commands and next state
    always_comb
    begin
        cmd        = '0;
        cmd.step   = step_reg;
        state_next = state_reg;
        step_next  = step_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    if (status.in_cal)
                    begin
                        cmd.cal_accept = 1'b1;
                        if (status.cal_last)
                        begin
                            state_next = ST_SORT;
                        end
                    end
                    else
                    begin
                        cmd.scan_accept = 1'b1;
                        if (status.group_last)
                        begin
                            state_next = ST_EVAL;
                        end
                    end
                end
            end
            ST_SORT:
            begin
                cmd.sort_step = 1'b1;
                cmd.sort_odd  = step_reg[0];
                step_next     = step_reg + 1'b1;
                if (step_end)
                begin
                    cmd.sum_clear = 1'b1;
                    step_next     = '0;
                    state_next    = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum_add = 1'b1;
                step_next   = step_reg + 1'b1;
                if (step_end)
                begin
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = ST_BOUT;
            end
            ST_BOUT:
            begin
                if (status.out_free)
                begin
                    cmd.base_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EVAL:
            begin
                if (status.out_free)
                begin
                    cmd.scan_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

FILE: src/touch_key_charge_time_detector.sv
// Top level of the touch key charge time detector: controller plus datapath.
// Depends on tkd_pkg, tkd_ctrl and tkd_datapath.
//
//   channel   signals                          transfer when
//   input     in_valid, in_stall, in_data      in_valid && !in_stall
//   output    out_valid, out_stall, out_data   out_valid && !out_stall
//   config    cfg_we, cfg_index, cfg_data      cfg_we
//
// A calibration sample that does not fill the store and a scan sample inside a
// group are only accepted. A group-ending scan sample is accepted, then given a verdict.
// The store-filling calibration sample runs accept, CAL_SAMPLES sort passes on
// the shared compare-swap row, KEEP sum adds on the single adder, one divide by
// the reciprocal multiply and the baseline load.
// Reset is asynchronous, active low; config returns to its reset values.
// A pending result holds the final load until out_stall drops; in_stall is high
// while an item is being worked.
`timescale 1ns / 1ps

module touch_key_charge_time_detector (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  tkd_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output tkd_pkg::out_t                  out_data,
    input  logic                           cfg_we,
    input  logic [tkd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tkd_pkg::CFG_DATA_W-1:0] cfg_data
);

    tkd_pkg::cmd_t    cmd;
    tkd_pkg::status_t status;

    // Sequencer
    tkd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Storage, arithmetic and result register
    tkd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
